FILE: rtl/core/ss_pkg.sv
// Shared types and constants for the streaming substring search block.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package ss_pkg;

    // Configuration registers hold a fixed needle of sixteen bytes.
    localparam int NEEDLE_CFG_BYTES = 16;
    localparam int CFG_DATA_W       = 64;
    localparam int CFG_INDEX_W      = 2;
    localparam int LENGTH_W         = 5;
    localparam int MATCH_START_W    = 16;

    // ASCII letters used by case folding.
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_NEEDLE_LOW    = 2'd0,
        REG_NEEDLE_HIGH   = 2'd1,
        REG_NEEDLE_LENGTH = 2'd2,
        REG_CASE_FOLD     = 2'd3
    } ss_reg_t;

    // Configuration state as seen by the compare logic.
    typedef struct packed {
        logic [8*NEEDLE_CFG_BYTES-1:0] needle;
        logic [LENGTH_W-1:0]           length;
        logic                          case_fold;
    } ss_cfg_t;

    // One input transfer: a haystack byte and its end-of-search mark.
    typedef struct packed {
        logic [7:0] haystack_byte;
        logic       last_byte;
    } ss_in_t;

    // One result transfer.
    typedef struct packed {
        logic                     found;
        logic [MATCH_START_W-1:0] match_start;
        logic                     position_overflow;
    } ss_out_t;

    // Lower an ASCII upper-case letter when folding is enabled.
    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic enable);
        logic [7:0] r;
        r = c;
        if (enable && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            r = c + (CHAR_LOWER_A - CHAR_UPPER_A);
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/ss_config.sv
// Configuration register file of the substring search: needle, length, fold.
// Depends on ss_pkg for the register indexes and the configuration struct.
`timescale 1ns / 1ps

module ss_config
    import ss_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output ss_cfg_t                cfg
);

    logic [CFG_DATA_W-1:0] needle_low_reg;
    logic [CFG_DATA_W-1:0] needle_high_reg;
    logic [LENGTH_W-1:0]   length_reg;
    logic                  fold_reg;

    // Write one register per enabled cycle; there is no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_low_reg  <= '0;
            needle_high_reg <= '0;
            length_reg      <= '0;
            fold_reg        <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (ss_reg_t'(cfg_index))
                REG_NEEDLE_LOW:    needle_low_reg  <= cfg_data;
                REG_NEEDLE_HIGH:   needle_high_reg <= cfg_data;
                REG_NEEDLE_LENGTH: length_reg      <= cfg_data[LENGTH_W-1:0];
                REG_CASE_FOLD:     fold_reg        <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    assign cfg.needle    = {needle_high_reg, needle_low_reg};
    assign cfg.length    = length_reg;
    assign cfg.case_fold = fold_reg;

endmodule

FILE: rtl/core/ss_compare.sv
// Parallel window compare of the substring search and result formatting.
// Depends on ss_pkg for the configuration and result types and the fold function.
`timescale 1ns / 1ps

module ss_compare
    import ss_pkg::*;
#(
    parameter int NEEDLE_BYTES  = 16,
    parameter int POSITION_BITS = 16
)
(
    input  ss_cfg_t                            cfg,
    input  logic [NEEDLE_BYTES-1:0][7:0]       window,
    input  logic [POSITION_BITS:0]             bytes_seen,
    output logic                               match,
    output ss_out_t                            result
);

    localparam int LEN_W = $clog2(NEEDLE_BYTES + 1);
    localparam int IDX_W = (NEEDLE_BYTES > 1) ? $clog2(NEEDLE_BYTES) : 1;
    localparam int EXT_BYTES = 1 << IDX_W;
    localparam int CNT_W = POSITION_BITS + 1;

    logic [LEN_W-1:0]               len;
    logic [EXT_BYTES-1:0][7:0]      needle_ext;
    logic [NEEDLE_BYTES-1:0]        hits;
    logic [CNT_W-1:0]               diff;
    logic [POSITION_BITS-1:0]       start_pos;

    // Needle lengths beyond the window are clamped to the window size.
    assign len = (32'(cfg.length) > NEEDLE_BYTES) ? LEN_W'(NEEDLE_BYTES)
                                                  : LEN_W'(cfg.length);

    // Needle bytes past the configured sixteen read as zero.
    for (genvar k = 0; k < EXT_BYTES; k++)
    begin : g_needle
        if (k < NEEDLE_CFG_BYTES)
        begin : g_cfg
            assign needle_ext[k] = cfg.needle[8*k +: 8];
        end
        else
        begin : g_zero
            assign needle_ext[k] = 8'h00;
        end
    end

    // Window byte j (0 is the newest) lines up with needle byte len-1-j.
    for (genvar j = 0; j < NEEDLE_BYTES; j++)
    begin : g_lane
        logic [IDX_W-1:0] idx;
        assign idx = IDX_W'(len - LEN_W'(j + 1));
        assign hits[j] = (LEN_W'(j) >= len) ||
            (fold_byte(window[j], cfg.case_fold) ==
             fold_byte(needle_ext[idx], cfg.case_fold));
    end

    assign match = (&hits) && (CNT_W'(len) <= bytes_seen);

    // Start position saturates at the top of the position range.
    assign diff = bytes_seen - CNT_W'(len);
    assign start_pos = (len == '0) ? '0 :
                       diff[POSITION_BITS] ? '1 : diff[POSITION_BITS-1:0];

    assign result.found             = match;
    assign result.match_start       = match ? MATCH_START_W'(start_pos) : '0;
    assign result.position_overflow = bytes_seen[POSITION_BITS] &&
                                      (|bytes_seen[POSITION_BITS-1:0]);

endmodule

FILE: rtl/core/substring_search.sv
// Channel    Dir  Handshake          Payload
// input      in   in_valid/in_stall  in_data  (haystack_byte, last_byte)
// result     out  out_valid/out_stall out_data (found, match_start, position_overflow)
// config     in   cfg_write          cfg_index, cfg_data
//
// One byte per cycle sustained while in_stall is low.
// The byte sits in an input register, is compared combinationally against the whole
// window, and the result lands in an output register.
// Reset clears the search state and the configuration; no clearing pass is needed.
// While a result waits under out_stall, bytes that produce no result still flow;
// the input stalls only when a second result would need the occupied output register.
//
// Top level of the streaming substring search; depends on ss_pkg, ss_config and
// ss_compare.
`timescale 1ns / 1ps

module substring_search
    import ss_pkg::*;
#(
    parameter int NEEDLE_BYTES  = 16,
    parameter int POSITION_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  ss_in_t                 in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output ss_out_t                out_data,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CNT_W = POSITION_BITS + 1;

    ss_cfg_t                       cfg;
    logic                          in_valid_reg;
    logic                          in_valid_next;
    ss_in_t                        in_item_reg;
    logic [NEEDLE_BYTES-1:0][7:0]  window_reg;
    logic [NEEDLE_BYTES-1:0][7:0]  window_next;
    logic [CNT_W-1:0]              seen_reg;
    logic [CNT_W-1:0]              seen_next;
    logic                          done_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    ss_out_t                       out_item_reg;
    ss_out_t                       result;
    logic                          match;
    logic                          emits;
    logic                          advance;

    ss_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Shift the new byte into the window and count it, saturating.
    always_comb
    begin
        window_next[0] = in_item_reg.haystack_byte;
        for (int j = 1; j < NEEDLE_BYTES; j++)
        begin
            window_next[j] = window_reg[j-1];
        end
        seen_next = (seen_reg == '1) ? seen_reg : seen_reg + CNT_W'(1);
    end

    ss_compare #(
        .NEEDLE_BYTES  (NEEDLE_BYTES),
        .POSITION_BITS (POSITION_BITS)
    ) u_compare (
        .cfg        (cfg),
        .window     (window_next),
        .bytes_seen (seen_next),
        .match      (match),
        .result     (result)
    );

    // A byte yields a result at the first match or at the end of an unmatched search.
    assign emits   = in_valid_reg && !done_reg && (match || in_item_reg.last_byte);
    assign advance = in_valid_reg && (!emits || !out_valid_reg || !out_stall);

    assign in_stall      = in_valid_reg && !advance;
    assign in_valid_next = in_stall || (in_valid && !in_stall);

    assign out_valid_next = (advance && emits) || (out_valid_reg && out_stall);

    // Input register, search state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seen_reg      <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                if (in_item_reg.last_byte)
                begin
                    seen_reg <= '0;
                    done_reg <= 1'b0;
                end
                else if (!done_reg)
                begin
                    seen_reg <= seen_next;
                    done_reg <= match;
                end
            end
        end
    end

    // Payload registers; window bytes beyond the count are never compared.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_data;
        end
        if (advance && !done_reg)
        begin
            window_reg <= window_next;
        end
        if (advance && emits)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

FILE: rtl/core/ss_checker.sv
// Port-level checks for the substring search, bound to the top level.
// Depends on ss_pkg for the payload types and on substring_search for the bind.
`timescale 1ns / 1ps

module ss_checker
    import ss_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input ss_out_t                out_data
);

    // A held result stays put until it is transferred.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // The input only backs up behind a stalled, occupied output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // An unmatched search reports position zero.
    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> out_data.match_start == '0)
        else $error("nonzero start on a failed search");

    // A new result follows an earlier transfer on the input.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without a preceding input transfer");

endmodule

bind substring_search ss_checker u_ss_checker (.*);
